// ===== design/usan_pkg.sv =====
package usan_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      num;
    logic            last;
    logic            valid;
  } usan_job_t;

endpackage

// ===== design/usan_front.sv =====
module usan_front import usan_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output usan_job_t  q_job_o
);

  logic [2:0][7:0] pend_q, pend_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      exp_q, exp_d;
  logic            nd_q, nd_d;
  logic            accept;

  function automatic logic single_ok(input logic [7:0] b);
    single_ok = (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
                ((b >= 8'h20) && (b <= 8'h7E));
  endfunction

  function automatic logic table_ok(input logic [7:0] lead, input logic [7:0] sec);
    logic ok;
    ok = 1'b0;
    if ((lead >= 8'hC2) && (lead <= 8'hDF)) ok = 1'b1;
    else if (lead == 8'hE0) ok = (sec >= 8'hA0);
    else if (lead == 8'hED) ok = (sec <= 8'h9F);
    else if ((lead >= 8'hE1) && (lead <= 8'hEF)) ok = 1'b1;
    else if (lead == 8'hF0) ok = (sec >= 8'h90);
    else if ((lead >= 8'hF1) && (lead <= 8'hF3)) ok = 1'b1;
    else if (lead == 8'hF4) ok = (sec <= 8'h8F);
    table_ok = ok;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic       handled;
    logic [7:0] b;
    logic [7:0] sec;
    b        = in_byte_i;
    handled  = 1'b0;
    sec      = 8'h00;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    exp_d    = exp_q;
    nd_d     = nd_q;
    q_job_o  = '0;

    if (exp_q != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        handled = 1'b1;
        if (({1'b0, cnt_q} + 3'd1) >= exp_q) begin
          sec = (cnt_q >= 2'd2) ? pend_q[1] : b;
          q_job_o.bytes[0] = pend_q[0];
          q_job_o.bytes[1] = sec;
          q_job_o.bytes[2] = (cnt_q == 2'd3) ? pend_q[2] : b;
          q_job_o.bytes[3] = b;
          if ((cnt_q >= 2'd1) && table_ok(pend_q[0], sec)) begin
            q_job_o.num = {1'b0, cnt_q} + 3'd1;
          end else begin
            nd_d = 1'b0;
          end
          cnt_d = 2'd0;
          exp_d = 3'd0;
        end else begin
          pend_d[cnt_q] = b;
          cnt_d = cnt_q + 2'd1;
        end
      end else begin
        nd_d  = 1'b0;
        cnt_d = 2'd0;
        exp_d = 3'd0;
      end
    end

    if (!handled) begin
      if (!b[7]) begin
        if (single_ok(b)) begin
          q_job_o.bytes[0] = b;
          q_job_o.num      = 3'd1;
        end else begin
          nd_d = 1'b0;
        end
      end else if ((b < 8'hC0) || (b >= 8'hF8)) begin
        nd_d = 1'b0;
      end else begin
        exp_d     = (b < 8'hE0) ? 3'd2 : (b < 8'hF0) ? 3'd3 : 3'd4;
        pend_d[0] = b;
        cnt_d     = 2'd1;
      end
    end

    q_job_o.last = end_of_text_i;
    if (end_of_text_i) begin
      if (exp_d != 3'd0) nd_d = 1'b0;
      q_job_o.valid = nd_d;
      cnt_d = 2'd0;
      exp_d = 3'd0;
      nd_d  = 1'b1;
    end
  end

  assign q_push_o = accept && ((q_job_o.num != 3'd0) || end_of_text_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      exp_q <= 3'd0;
      nd_q  <= 1'b1;
    end else if (accept) begin
      cnt_q <= cnt_d;
      exp_q <= exp_d;
      nd_q  <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pend_q <= pend_d;
  end

endmodule

// ===== design/usan_fifo.sv =====
module usan_fifo import usan_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  usan_job_t job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output usan_job_t job_o
);

  usan_job_t            mem_q [QDepth];
  logic [PtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

endmodule

// ===== design/usan_back.sv =====
module usan_back import usan_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  usan_job_t  q_job_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       run_last_o,
  output logic       text_end_o,
  output logic       text_was_valid_o
);

  logic [1:0] idx_q, idx_d;
  logic [2:0] num_m1;
  logic [1:0] last_idx;
  logic       is_last, fire;

  assign num_m1   = q_job_i.num - 3'd1;
  assign last_idx = (q_job_i.num == 3'd0) ? 2'd0 : num_m1[1:0];
  assign is_last  = (idx_q == last_idx);

  assign out_valid_o      = !q_empty_i;
  assign fire             = out_valid_o && out_ready_i;
  assign q_pop_o          = fire && is_last;
  assign byte_present_o   = (q_job_i.num != 3'd0);
  assign out_byte_o       = byte_present_o ? q_job_i.bytes[idx_q] : 8'h00;
  assign run_last_o       = is_last;
  assign text_end_o       = is_last && q_job_i.last;
  assign text_was_valid_o = text_end_o && q_job_i.valid;

  always_comb begin
    idx_d = idx_q;
    if (fire) idx_d = is_last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== design/utf8_stream_sanitizer_top.sv =====
// UTF-8 stream sanitizer.
// Input channel (in_valid_i/in_ready_o): one text byte per word with an
// end_of_text_i flag on the final byte. Output channel (out_valid_o/
// out_ready_i): one kept byte per word, with run_last_o on the last word
// caused by an input byte, and text_end_o/text_was_valid_o on the final
// word of a text (a word with byte_present_o low is a bare end marker).
// A result word is written into the job queue when the byte that
// completes it is taken. The block takes up to one input byte per cycle
// while the queue is not full; a completed character of N bytes gives N
// words, one per cycle while out_ready_i is high, fed from a two-entry job
// queue between the classifier and the output sequencer. Bytes that only
// extend an open sequence produce no word. Single bytes right behind a
// long character can fill the queue and hold in_ready_o low, also in the
// cycle a full queue pops. When the receiver stalls, the queue fills and
// in_ready_o drops once it holds two jobs; nothing is lost. Reset clears
// the queue, closes any open sequence and marks the text as clean.
module utf8_stream_sanitizer_top import usan_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       run_last_o,
  output logic       text_end_o,
  output logic       text_was_valid_o
);

  usan_job_t push_job, head_job;
  logic      q_push, q_full, q_pop, q_empty;

  usan_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (push_job)
  );

  usan_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  usan_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_job_i          (head_job),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .byte_present_o   (byte_present_o),
    .run_last_o       (run_last_o),
    .text_end_o       (text_end_o),
    .text_was_valid_o (text_was_valid_o)
  );

  a_marker_ends_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_present_o) |-> (text_end_o && run_last_o && out_byte_o == 8'h00))
    else $error("end marker without text end");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_end_o) |-> run_last_o)
    else $error("text end not on last word of run");

  a_valid_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !text_end_o) |-> !text_was_valid_o)
    else $error("valid flag outside text end");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !in_ready_o)
    else $error("input taken while queue full");

endmodule

// ===== sim/usan_checker.sv =====
module usan_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        byte_present_i,
  input  logic        run_last_i,
  input  logic        text_end_i,
  input  logic        text_was_valid_i,
  output int unsigned errors_o,
  output int unsigned outstanding_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;
  localparam logic [7:0] TabChar = 8'h09;
  localparam logic [7:0] LfChar  = 8'h0A;
  localparam logic [7:0] CrChar  = 8'h0D;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       run_last;
    logic       text_end;
    logic       was_valid;
  } word_t;

  word_t       kept_words[$];
  logic [7:0]  held [3];
  int unsigned held_cnt;
  int unsigned open_len;
  logic        clean;

  function automatic logic single_ok(input logic [7:0] b);
    return b == TabChar || b == LfChar || b == CrChar || (b >= 8'h20 && b <= 8'h7E);
  endfunction

  function automatic logic in_table(input logic [7:0] lead, input logic [7:0] second);
    if (lead >= 8'hC2 && lead <= 8'hDF) return 1'b1;
    if (lead == 8'hE0) return second >= 8'hA0;
    if (lead == 8'hED) return second <= 8'h9F;
    if (lead >= 8'hE1 && lead <= 8'hEF) return 1'b1;
    if (lead == 8'hF0) return second >= 8'h90;
    if (lead >= 8'hF1 && lead <= 8'hF3) return 1'b1;
    if (lead == 8'hF4) return second <= 8'h8F;
    return 1'b0;
  endfunction

  task automatic filter_byte(input logic [7:0] b, input logic eot);
    word_t       words [4];
    logic [7:0]  seq [4];
    int unsigned n;
    int unsigned i;
    logic        handled;
    n = 0;
    handled = 1'b0;
    if (open_len != 0) begin
      if (b[7:6] == 2'b10) begin
        handled = 1'b1;
        if (held_cnt + 1 >= open_len) begin
          for (i = 0; i < held_cnt; i++) seq[i] = held[i];
          seq[held_cnt] = b;
          if (held_cnt >= 1 && in_table(seq[0], seq[1])) begin
            for (i = 0; i <= held_cnt; i++) begin
              words[n] = '{seq[i], 1'b1, 1'b0, 1'b0, 1'b0};
              n++;
            end
          end else begin
            clean = 1'b0;
          end
          held_cnt = 0;
          open_len = 0;
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end else begin
        clean = 1'b0;
        held_cnt = 0;
        open_len = 0;
      end
    end
    if (!handled) begin
      if (b < 8'h80) begin
        if (single_ok(b)) begin
          words[n] = '{b, 1'b1, 1'b0, 1'b0, 1'b0};
          n++;
        end else begin
          clean = 1'b0;
        end
      end else if (b < 8'hC0 || b >= 8'hF8) begin
        clean = 1'b0;
      end else begin
        open_len = (b < 8'hE0) ? 2 : (b < 8'hF0) ? 3 : 4;
        held[0] = b;
        held_cnt = 1;
      end
    end
    if (n != 0) words[n-1].run_last = 1'b1;
    if (eot) begin
      if (open_len != 0) clean = 1'b0;
      if (n == 0) begin
        words[0] = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
        n = 1;
      end
      words[n-1].text_end = 1'b1;
      words[n-1].was_valid = clean;
      held_cnt = 0;
      open_len = 0;
      clean = 1'b1;
    end
    for (i = 0; i < n; i++) kept_words = {kept_words, words[i]};
  endtask

  task automatic report(input string what, input word_t want, input word_t got);
    errors_o++;
    if (errors_o <= ReportLimit) begin
      $display("%0t: %s at word %0d: expected byte=%h present=%b run_last=%b end=%b valid=%b",
               $realtime, what, checked_o, want.data, want.present, want.run_last,
               want.text_end, want.was_valid);
      $display("%0t:   got byte=%h present=%b run_last=%b end=%b valid=%b",
               $realtime, got.data, got.present, got.run_last, got.text_end, got.was_valid);
    end
  endtask

  task automatic check_word(input word_t got);
    word_t want;
    if (kept_words.size() == 0) begin
      report("unexpected word", '0, got);
    end else begin
      want = kept_words.pop_front();
      if (got !== want) report("wrong word", want, got);
    end
    checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_words.delete();
      held_cnt = 0;
      open_len = 0;
      clean = 1'b1;
      errors_o = 0;
      outstanding_o = 0;
      checked_o = 0;
    end else begin
      // check first: a byte's words pass the job queue register, so they never leave in the cycle it enters
      if (out_valid_i && out_ready_i) begin
        check_word('{out_byte_i, byte_present_i, run_last_i, text_end_i, text_was_valid_i});
      end
      if (in_valid_i && in_ready_i) filter_byte(in_byte_i, end_of_text_i);
      outstanding_o = kept_words.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned RandomBytes = 303;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned NumDirected = 27;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_present_o;
  logic        run_last_o;
  logic        text_end_o;
  logic        text_was_valid_o;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned stuck;
  int unsigned bytes_sent;
  int unsigned texts_sent;
  logic        in_took;
  logic [8:0]  directed [NumDirected];
  logic [7:0]  text_q[$];

  always #1 clk_i = ~clk_i;

  utf8_stream_sanitizer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .byte_present_o  (byte_present_o),
    .run_last_o      (run_last_o),
    .text_end_o      (text_end_o),
    .text_was_valid_o(text_was_valid_o)
  );

  usan_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_i      (out_byte_o),
    .byte_present_i  (byte_present_o),
    .run_last_i      (run_last_o),
    .text_end_i      (text_end_o),
    .text_was_valid_i(text_was_valid_o),
    .errors_o        (errors),
    .outstanding_o   (outstanding),
    .checked_o       (checked)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
      stuck <= 0;
    end else begin
      in_took <= in_valid_i && in_ready_o;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck <= 0;
      end else if (stuck + 1 >= StuckLimit) begin
        $display("utf8_stream_sanitizer_top: mismatch");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  function automatic int unsigned pick_len(input int unsigned zero_pct,
                                           input int unsigned long_pct,
                                           input int unsigned long_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 92 - long_pct) return $urandom_range(1, 3);
    if (r < 100 - long_pct) return $urandom_range(4, 10);
    return $urandom_range(long_max / 2, long_max);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot, input logic steady);
    int unsigned gap;
    gap = steady ? 0 : pick_len(60, 3, 40);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_byte_i = b;
    end_of_text_i = eot;
    in_valid_i = 1'b1;
    do @(negedge clk_i); while (!in_took);
    bytes_sent++;
    if (eot) texts_sent++;
  endtask

  task automatic wait_for_drain();
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic append_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic add_char();
    int unsigned r;
    int unsigned k;
    int unsigned len;
    int unsigned nbytes;
    logic [7:0]  lead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    r = $urandom_range(0, 99);
    if (r < 28) begin
      k = $urandom_range(0, 9);
      append_byte(k == 0 ? 8'h09 : k == 1 ? 8'h0A : k == 2 ? 8'h0D :
                  8'($urandom_range(8'h20, 8'h7E)));
    end else if (r < 34) begin
      append_byte(8'($urandom_range(0, 255)));
    end else if (r < 38) begin
      append_byte(8'($urandom_range(8'h80, 8'hBF)));
    end else begin
      len = (r < 52) ? 2 : (r < 72) ? 3 : 4;
      lead = (len == 2) ? 8'($urandom_range(8'hC2, 8'hDF)) :
             (len == 3) ? 8'($urandom_range(8'hE0, 8'hEF)) :
                          8'($urandom_range(8'hF0, 8'hF4));
      lo = 8'h80;
      hi = 8'hBF;
      if (lead == 8'hE0) lo = 8'hA0;
      if (lead == 8'hED) hi = 8'h9F;
      if (lead == 8'hF0) lo = 8'h90;
      if (lead == 8'hF4) hi = 8'h8F;
      k = $urandom_range(0, 99);
      nbytes = len;
      if (k < 8) begin
        lo = 8'h80;
        hi = 8'hBF;
      end else if (k < 12 && len == 2) begin
        lead = 8'hC0 + 8'($urandom_range(0, 1));
      end else if (k < 12 && len == 4) begin
        lead = 8'hF5 + 8'($urandom_range(0, 2));
      end else if (k < 20) begin
        nbytes = $urandom_range(1, len - 1);
      end
      append_byte(lead);
      if (nbytes > 1) append_byte(8'($urandom_range(lo, hi)));
      for (k = 2; k < nbytes; k++) append_byte(8'($urandom_range(8'h80, 8'hBF)));
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      out_ready_i = 1'b1;
      repeat (pick_len(0, 15, 120)) @(negedge clk_i);
      out_ready_i = 1'b0;
      repeat (pick_len(0, 5, 60)) @(negedge clk_i);
    end
  end

  initial begin
    int unsigned i;
    logic        steady;
    directed = '{9'h009, 9'h00A, 9'h00D, 9'h020, 9'h07E, 9'h000, 9'h17F,
                 9'h0C2, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0E0, 9'h0A0, 9'h180,
                 9'h080, 9'h0FF, 9'h0C0, 9'h080, 9'h0C3, 9'h041, 9'h0ED, 9'h0A0, 9'h080,
                 9'h0E2, 9'h182};
    bytes_sent = 0;
    texts_sent = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < NumDirected; i++) send_byte(directed[i][7:0], directed[i][8], 1'b0);

    while (bytes_sent < NumDirected + RandomBytes) begin
      text_q.delete();
      repeat ($urandom_range(1, 10)) add_char();
      steady = ($urandom_range(0, 4) == 0);
      for (i = 0; i < text_q.size(); i++) begin
        send_byte(text_q[i], i == text_q.size() - 1, steady);
      end
      if (texts_sent % 12 == 5) begin
        in_valid_i = 1'b0;
        wait_for_drain();
      end
    end

    in_valid_i = 1'b0;
    wait_for_drain();
    repeat (TailCycles) @(negedge clk_i);

    $display("sent %0d bytes in %0d texts, checked %0d output words", bytes_sent, texts_sent,
             checked);
    $display("mix: allowed ASCII, 2-4 byte characters, table edges, bad leads, truncation, noise");
    if (errors == 0 && outstanding == 0) begin
      $display("utf8_stream_sanitizer_top: match");
    end else begin
      $display("utf8_stream_sanitizer_top: mismatch");
    end
    $finish;
  end

endmodule
